// ===== rtl/csm_pkg.sv =====
// Shared types and constants of the CSR sparse matrix-vector block.
// No dependencies; the top level, the datapath, the checker and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

   // Item modes.
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_NONZERO = 2'd1;
   localparam logic [1:0] MODE_EMPTY   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_BETA  = 1'b1;

   // Register reset values.
   localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
   localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

   // Multiplier operand selection.
   localparam logic [1:0] MUL_X        = 2'd0;
   localparam logic [1:0] MUL_ALPHA_LO = 2'd1;
   localparam logic [1:0] MUL_ALPHA_HI = 2'd2;
   localparam logic [1:0] MUL_BETA     = 2'd3;

   // Operations on the row result sum.
   localparam logic [1:0] SUM_HOLD     = 2'd0;
   localparam logic [1:0] SUM_LOAD     = 2'd1;
   localparam logic [1:0] SUM_ADD_HI   = 2'd2;
   localparam logic [1:0] SUM_ADD_PROD = 2'd3;

   // Widths of the shared 33 x 33 multiplier and of the exact row sum.
   localparam int PROD_W = 66;
   localparam int SUM_W  = 98;

   // Input word.
   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] old_y;
      logic               last_in_row;
   } req_type;

   // Result word.
   typedef struct packed {
      logic signed [31:0] y_value;
      logic               saturated;
   } rsp_type;

   // Datapath controls that the sequencer issues in each state.
   typedef struct packed {
      logic [1:0] mul_sel;
      logic       acc_add;
      logic       acc_clear;
      logic [1:0] sum_op;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/csr_sparse_matvec.sv =====
// Top level of the CSR sparse matrix-vector block: sequencer, registers, result word.
// Depends on csm_pkg, csm_xstore and csm_datapath.
//
// Use: stream words on the req_ channel. A load word (mode 0) writes one x
// element; a nonzero word (mode 1) multiplies its value by the stored x
// element and adds the truncated product to the row accumulator; a nonzero
// with last_in_row, or an empty-row word (mode 2), produces one result word
// alpha*sum + beta*old_y, saturated to 32 bits, and clears the accumulator.
// alpha_gain and beta_gain are written over the APB port at 0x0 and 0x4.
// Steps per word: a load is written at once; a nonzero that does not close its
// row runs x store read, multiply and accumulate; a row-closing nonzero runs
// these and then the row end; an empty row runs only the row end. The row end
// runs three passes through the one shared 33 x 33 multiplier, an add, then a
// rescale and clamp stage. req_stall holds off new words until the sequencer is
// idle again; the result word is loaded once the output register is free.
// The result sits in an output register: while rsp_stall holds it, the block
// keeps accepting words and stops only when a new row result must be loaded.
// Reset clears the sequencer, the accumulator, the output valid and sets
// alpha to 1.0 and beta to 0. The x store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module csr_sparse_matvec #(
   parameter int X_DEPTH   = 1024,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire csm_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output csm_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   import csm_pkg::*;

   localparam int ADDR_W = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
   localparam logic [31:0] DEPTH_LIMIT = 32'(X_DEPTH);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_XMUL  = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_FLO   = 3'd3;
   localparam logic [2:0] ST_FHI   = 3'd4;
   localparam logic [2:0] ST_FBETA = 3'd5;
   localparam logic [2:0] ST_FADD  = 3'd6;
   localparam logic [2:0] ST_FOUT  = 3'd7;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic               req_accept;
   logic               in_range;
   logic [31:0]        index_ext;
   logic [ADDR_W-1:0]  x_addr;
   logic [31:0]        x_value;
   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic signed [31:0] old_y_ff;
   logic signed [31:0] old_y_in;
   logic               last_ff;
   logic               last_in;
   logic               range_ff;
   logic               range_in;
   logic [31:0]        alpha_ff;
   logic [31:0]        alpha_in;
   logic [31:0]        beta_ff;
   logic [31:0]        beta_in;
   logic               cfg_write;
   ctl_type            ctl;
   rsp_type            result;
   logic               out_free;
   logic               out_load;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   // Input handshake and x store addressing.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign index_ext  = 32'(req_data.element_index);
   assign x_addr     = index_ext[ADDR_W-1:0];
   assign in_range   = (index_ext < DEPTH_LIMIT);

   csm_xstore #(
      .DEPTH  (X_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_xstore (
      .clock   (clock),
      .wr_en   (req_accept && req_data.mode == MODE_LOAD && in_range),
      .wr_addr (x_addr),
      .wr_data (req_data.element_value),
      .rd_en   (req_accept && req_data.mode == MODE_NONZERO),
      .rd_addr (x_addr),
      .rd_data (x_value)
   );

   // Fields of the word in work are held until its row end.
   always_comb begin
      value_in = value_ff;
      old_y_in = old_y_ff;
      last_in  = last_ff;
      range_in = range_ff;
      if (req_accept) begin
         value_in = req_data.element_value;
         old_y_in = req_data.old_y;
         last_in  = req_data.last_in_row;
         range_in = in_range;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      old_y_ff <= old_y_in;
      last_ff  <= last_in;
      range_ff <= range_in;
   end

   // Sequencer: one multiplier pass in each of the XMUL, FLO, FHI and FBETA states.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      ctl.mul_sel   = MUL_X;
      ctl.acc_add   = 1'b0;
      ctl.acc_clear = 1'b0;
      ctl.sum_op    = SUM_HOLD;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.mode == MODE_NONZERO) begin
                  state_in = ST_XMUL;
               end else if (req_data.mode == MODE_EMPTY) begin
                  state_in = ST_FLO;
               end
            end
         end
         ST_XMUL: begin
            ctl.mul_sel = MUL_X;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            ctl.acc_add = 1'b1;
            state_in    = last_ff ? ST_FLO : ST_IDLE;
         end
         ST_FLO: begin
            ctl.mul_sel = MUL_ALPHA_LO;
            state_in    = ST_FHI;
         end
         ST_FHI: begin
            ctl.mul_sel   = MUL_ALPHA_HI;
            ctl.sum_op    = SUM_LOAD;
            ctl.acc_clear = 1'b1;
            state_in      = ST_FBETA;
         end
         ST_FBETA: begin
            ctl.mul_sel = MUL_BETA;
            ctl.sum_op  = SUM_ADD_HI;
            state_in    = ST_FADD;
         end
         ST_FADD: begin
            ctl.sum_op = SUM_ADD_PROD;
            state_in   = ST_FOUT;
         end
         ST_FOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   csm_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .element_value (value_ff),
      .old_y         (old_y_ff),
      .x_value       (x_value),
      .x_in_range    (range_ff),
      .alpha_gain    (alpha_ff),
      .beta_gain     (beta_ff),
      .result        (result)
   );

   // Output register for the result word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration registers on the APB port.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (cfg_write) begin
         if (paddr[2] == REG_ALPHA) begin
            alpha_in = pwdata;
         end else begin
            beta_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   assign prdata = (paddr[2] == REG_BETA) ? beta_ff : alpha_ff;

endmodule

`default_nettype wire

// ===== rtl/csm_xstore.sv =====
// Local store of the x vector: one write port, one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module csm_xstore #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/csm_datapath.sv =====
// Shared multiplier, row accumulator, exact row sum and saturation.
// Depends on csm_pkg; steered cycle by cycle by the top-level sequencer.
`timescale 1ns / 1ps
`default_nettype none

module csm_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire csm_pkg::ctl_type     ctl,
   input  wire logic signed [31:0]   element_value,
   input  wire logic signed [31:0]   old_y,
   input  wire logic [31:0]          x_value,
   input  wire logic                 x_in_range,
   input  wire logic [31:0]          alpha_gain,
   input  wire logic [31:0]          beta_gain,
   output csm_pkg::rsp_type          result
);

   import csm_pkg::*;

   logic signed [32:0]       mul_a;
   logic signed [32:0]       mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [63:0]       prod_shifted;
   logic [63:0]              acc_ff;
   logic [63:0]              acc_in;
   logic signed [SUM_W-1:0]  prod_ext;
   logic signed [SUM_W-1:0]  prod_hi;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_shifted;
   logic [SUM_W-32:0]        sum_upper;
   logic                     fits;

   // Operand selection for the one multiplier.
   always_comb begin
      case (ctl.mul_sel)
         MUL_X: begin
            mul_a = {element_value[31], element_value};
            mul_b = x_in_range ? {x_value[31], x_value} : 33'sd0;
         end
         MUL_ALPHA_LO: begin
            mul_a = {alpha_gain[31], alpha_gain};
            mul_b = {1'b0, acc_ff[31:0]};
         end
         MUL_ALPHA_HI: begin
            mul_a = {alpha_gain[31], alpha_gain};
            mul_b = {acc_ff[63], acc_ff[63:32]};
         end
         default: begin
            mul_a = {beta_gain[31], beta_gain};
            mul_b = {old_y[31], old_y};
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Truncated nonzero product added into the row accumulator.
   assign prod_shifted = $signed(prod_ff[63:0]) >>> FRAC_BITS;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clear) begin
         acc_in = 64'd0;
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + prod_shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Exact alpha*acc + beta*old_y built from three partial products.
   assign prod_ext = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_hi  = {prod_ext[SUM_W-33:0], 32'd0};

   always_comb begin
      case (ctl.sum_op)
         SUM_LOAD:     sum_in = prod_ext;
         SUM_ADD_HI:   sum_in = sum_ff + prod_hi;
         SUM_ADD_PROD: sum_in = sum_ff + prod_ext;
         default:      sum_in = sum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Rescale and clamp to 32 bits.
   assign sum_shifted = sum_ff >>> FRAC_BITS;
   assign sum_upper   = sum_shifted[SUM_W-1:31];
   assign fits        = (&sum_upper) | ~(|sum_upper);

   always_comb begin
      result.saturated = ~fits;
      if (fits) begin
         result.y_value = sum_shifted[31:0];
      end else if (sum_shifted[SUM_W-1]) begin
         result.y_value = 32'sh8000_0000;
      end else begin
         result.y_value = 32'sh7FFF_FFFF;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/csm_checker.sv =====
// Port-level checks of the CSR sparse matrix-vector block, bound to its top level.
// Depends on csm_pkg and on the port list of csr_sparse_matvec.
`timescale 1ns / 1ps
`default_nettype none

module csm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire csm_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire csm_pkg::rsp_type rsp_data
);

   import csm_pkg::*;

   // A stalled result word stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   // The cycle after reset shows no result word.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A load word finishes in its own cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_LOAD |=> !req_stall)
      else $error("block busy after a load word");

   // A nonzero word keeps the block busy for its multiply.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_NONZERO |=> req_stall)
      else $error("nonzero word did not occupy the block");

   // A new result word only comes out of a busy row end.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared without a row end");

endmodule

bind csr_sparse_matvec csm_checker u_checker (.*);

`default_nettype wire

// ===== verif/csr_sparse_matvec_tb.sv =====
// Self-checking testbench for csr_sparse_matvec: streams x loads, nonzeros and empty rows,
// predicts every row result in place and compares it with the result channel.
// Depends on csm_pkg and the csr_sparse_matvec RTL; reads no files.
`timescale 1ns / 1ps

module csr_sparse_matvec_tb;
   import csm_pkg::*;

   localparam int X_DEPTH          = 1024;
   localparam int FRAC_BITS        = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_LIMIT     = 100000;
   localparam int SETTLE_PAUSE     = 20;

   // Mode 3 has no name in the package; the block must ignore it.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Byte addresses of the gain registers.
   localparam logic [2:0] ALPHA_ADDR = {REG_ALPHA, 2'b00};
   localparam logic [2:0] BETA_ADDR  = {REG_BETA, 2'b00};

   // Saturation bounds of a row result.
   localparam logic signed [127:0] Y_MAX = 128'sd2147483647;
   localparam logic signed [127:0] Y_MIN = -128'sd2147483648;

   typedef struct {
      req_type word;
      bit      drain;
   } feed_entry;

   // Block ports.
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   // Words waiting to be sent and row results waiting to arrive.
   feed_entry   word_queue[$];
   rsp_type     pending_y[$];

   // Predicted state of the block.
   logic signed [31:0] x_vec [X_DEPTH];
   logic signed [63:0] row_sum;
   logic signed [31:0] alpha_gain;
   logic signed [31:0] beta_gain;

   // Stimulus bookkeeping: which x elements have been loaded so far.
   bit          x_ready [X_DEPTH];
   logic [9:0]  ready_cols[$];
   int          words_queued = 0;

   // Handshake and idling control.
   logic        req_fired = 1'b0;
   logic        rsp_fired = 1'b0;
   bit          idle_on = 1'b1;
   int          feed_gap = 0;
   int          sink_gap = 0;
   int          long_hold_asked = 0;
   int          long_hold_served = 0;
   int          long_hold_left = 0;
   int          failures = 0;

   csr_sparse_matvec #(
      .X_DEPTH   (X_DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // Row end: alpha*sum + beta*old_y formed exactly, rescaled and clamped to 32 bits.
   function automatic rsp_type close_row(input logic signed [31:0] prior_y);
      logic signed [127:0] sum_w, alpha_w, beta_w, y_w, total;
      rsp_type r;
      sum_w   = row_sum;
      alpha_w = alpha_gain;
      beta_w  = beta_gain;
      y_w     = prior_y;
      total   = (sum_w * alpha_w + beta_w * y_w) >>> FRAC_BITS;
      if (total > Y_MAX) begin
         r.y_value   = 32'sh7fff_ffff;
         r.saturated = 1'b1;
      end else if (total < Y_MIN) begin
         r.y_value   = 32'sh8000_0000;
         r.saturated = 1'b1;
      end else begin
         r.y_value   = total[31:0];
         r.saturated = 1'b0;
      end
      row_sum = '0;
      return r;
   endfunction

   // Apply one accepted word to the predicted state; queue its row result if it has one.
   function automatic void advance_rows(input req_type w);
      logic signed [63:0] lhs, rhs, prod;
      case (w.mode)
         MODE_LOAD: begin
            x_vec[w.element_index] = w.element_value;
         end
         MODE_NONZERO: begin
            lhs     = $signed(w.element_value);
            rhs     = x_vec[w.element_index];
            prod    = lhs * rhs;
            row_sum = row_sum + (prod >>> FRAC_BITS);
            if (w.last_in_row)
               pending_y.push_back(close_row(w.old_y));
         end
         MODE_EMPTY: begin
            pending_y.push_back(close_row(w.old_y));
         end
         default: ;
      endcase
   endfunction

   // Monitor: acceptances on both channels and register accesses, sampled at the rising edge.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         req_fired  <= 1'b0;
         rsp_fired  <= 1'b0;
         row_sum    = '0;
         alpha_gain = ALPHA_RESET;
         beta_gain  = BETA_RESET;
      end else begin
         req_fired <= req_valid && !req_stall;
         rsp_fired <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall)
            advance_rows(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_y.size() == 0) begin
               $error("unexpected result word: y_value %0d saturated %0b",
                      $signed(rsp_data.y_value), rsp_data.saturated);
               failures++;
            end else begin
               want = pending_y.pop_front();
               if (rsp_data.y_value !== want.y_value) begin
                  $error("y_value: expected %0d, got %0d",
                         $signed(want.y_value), $signed(rsp_data.y_value));
                  failures++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b",
                         want.saturated, rsp_data.saturated);
                  failures++;
               end
            end
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ALPHA_ADDR)
                  alpha_gain = pwdata;
               else if (paddr == BETA_ADDR)
                  beta_gain = pwdata;
            end else if (prdata !== (paddr == ALPHA_ADDR ? alpha_gain : beta_gain)) begin
               $error("gain register at 0x%0h: expected 0x%08h, got 0x%08h", paddr,
                      paddr == ALPHA_ADDR ? alpha_gain : beta_gain, prdata);
               failures++;
            end
         end
      end
   end

   // Driver: offers the next queued word, after a random gap when idling is on; drain markers
   // hold it back until every pending row result has come out.
   always @(negedge clock) begin : feed_driver
      feed_entry head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (feed_gap > 0) begin
            feed_gap  <= feed_gap - 1;
            req_valid <= 1'b0;
         end else if (word_queue.size() > 0 && word_queue[0].drain) begin
            req_valid <= 1'b0;
            if (pending_y.size() == 0)
               void'(word_queue.pop_front());
         end else if (word_queue.size() > 0) begin
            head      = word_queue.pop_front();
            req_data  <= head.word;
            req_valid <= 1'b1;
            feed_gap  <= idle_on ? $urandom_range(0, 9) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall before each result word when idling is on, plus long hold-offs on request.
   always @(negedge clock) begin : result_sink
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fired)
            sink_gap = idle_on ? $urandom_range(0, 9) : 0;
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_asked != long_hold_served) begin
            long_hold_served++;
            long_hold_left = LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (sink_gap > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid)
               sink_gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Queue one word and track which x elements it makes readable.
   function automatic void queue_word(input logic [1:0] mode, input logic [9:0] idx,
                                      input logic [31:0] val, input logic [31:0] prior_y,
                                      input logic last);
      feed_entry e;
      e.drain                    = 1'b0;
      e.word.mode                = mode;
      e.word.element_index       = idx;
      e.word.element_value       = val;
      e.word.old_y               = prior_y;
      e.word.last_in_row         = last;
      word_queue.push_back(e);
      if (mode != MODE_UNUSED)
         words_queued++;
      if (mode == MODE_LOAD && !x_ready[idx]) begin
         x_ready[idx] = 1'b1;
         ready_cols.push_back(idx);
      end
   endfunction

   function automatic void queue_drain();
      feed_entry e;
      e.word  = '0;
      e.drain = 1'b1;
      word_queue.push_back(e);
   endfunction

   // Q16.16 value: extremes now and then, often full range, mostly small magnitudes.
   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7fff_ffff;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return $urandom_range(0, 32'h7_ffff) - 32'h4_0000;
      endcase
   endfunction

   // Column of a nonzero: only x elements already loaded are read.
   function automatic logic [9:0] pick_col();
      return ready_cols[$urandom_range(0, ready_cols.size() - 1)];
   endfunction

   // Random traffic: mostly well-formed rows, plus empty rows, loads, noise and broken rows.
   function automatic void queue_rows(input int quota);
      int goal, kind, len;
      goal = words_queued + quota;
      while (words_queued < goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            repeat ($urandom_range(0, 2))
               queue_word(MODE_LOAD, 10'($urandom), pick_q16(), $urandom, 1'($urandom));
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               // A load inside a row must leave the row sum alone.
               if ($urandom_range(0, 9) == 0)
                  queue_word(MODE_LOAD, 10'($urandom), pick_q16(), $urandom,
                             1'($urandom));
               queue_word(MODE_NONZERO, pick_col(), pick_q16(), pick_q16(), k == len - 1);
            end
         end else if (kind < 75) begin
            queue_word(MODE_EMPTY, 10'($urandom), $urandom, pick_q16(), 1'($urandom));
         end else if (kind < 80) begin
            queue_word(MODE_UNUSED, 10'($urandom), $urandom, $urandom, 1'($urandom));
         end else if (kind < 88) begin
            // Row cut short by an empty-row word that closes it with the partial sum.
            repeat ($urandom_range(1, 3))
               queue_word(MODE_NONZERO, pick_col(), pick_q16(), $urandom, 1'b0);
            queue_word(MODE_EMPTY, 10'($urandom), $urandom, pick_q16(), 1'($urandom));
         end else begin
            queue_word(MODE_LOAD, 10'($urandom), pick_q16(), $urandom, 1'($urandom));
         end
      end
   endfunction

   // Wait until all words are sent and all results are in, then let the pipeline empty.
   task automatic settle_block();
      int waited;
      waited = 0;
      while ((word_queue.size() != 0 || req_valid || pending_y.size() != 0)
             && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= SETTLE_LIMIT) begin
         $error("block did not settle: %0d row results outstanding", pending_y.size());
         failures++;
      end
      repeat (SETTLE_PAUSE) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle.
   task automatic gain_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_gains(input logic [31:0] alpha, input logic [31:0] beta);
      gain_access(1'b1, ALPHA_ADDR, alpha);
      gain_access(1'b1, BETA_ADDR, beta);
      gain_access(1'b0, ALPHA_ADDR, '0);
      gain_access(1'b0, BETA_ADDR, '0);
   endtask

   initial begin : run_phases
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at reset gains (alpha 1.0, beta 0).
      queue_word(MODE_LOAD, 10'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
      queue_word(MODE_LOAD, 10'd1023, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      queue_word(MODE_LOAD, 10'd5, 32'h0001_0000, 32'h0, 1'b0);
      queue_word(MODE_LOAD, 10'd6, 32'hffff_ffff, 32'h0, 1'b0);
      queue_word(MODE_NONZERO, 10'd5, 32'h0001_0000, 32'h7fff_ffff, 1'b1);
      // Negative products truncate toward minus infinity.
      queue_word(MODE_NONZERO, 10'd6, 32'h0000_0001, 32'h0, 1'b0);
      queue_word(MODE_NONZERO, 10'd6, 32'hffff_ffff, 32'h0, 1'b1);
      // Load inside a row, then a row that saturates high.
      queue_word(MODE_NONZERO, 10'd0, 32'h7fff_ffff, 32'h0, 1'b0);
      queue_word(MODE_LOAD, 10'd7, 32'h0, 32'hffff_ffff, 1'b1);
      queue_word(MODE_NONZERO, 10'd0, 32'h7fff_ffff, 32'h0, 1'b1);
      queue_word(MODE_NONZERO, 10'd1023, 32'h7fff_ffff, 32'h0, 1'b1);
      queue_word(MODE_NONZERO, 10'd1023, 32'h8000_0000, 32'h0, 1'b1);
      queue_word(MODE_EMPTY, 10'd0, 32'h0, 32'h8000_0000, 1'b1);
      queue_word(MODE_UNUSED, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      // Empty-row word in the middle of a row closes it with the partial sum.
      queue_word(MODE_NONZERO, 10'd5, 32'h0003_0000, 32'h0, 1'b0);
      queue_word(MODE_EMPTY, 10'h3ff, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
      queue_word(MODE_NONZERO, 10'd7, 32'h8000_0000, 32'h0, 1'b1);
      // Exact extremes that must not be flagged.
      queue_word(MODE_NONZERO, 10'd5, 32'h7fff_ffff, 32'h0, 1'b1);
      queue_word(MODE_NONZERO, 10'd5, 32'h8000_0000, 32'h0, 1'b1);
      settle_block();

      // Reset values read back, then extreme gains with random idling.
      gain_access(1'b0, ALPHA_ADDR, '0);
      gain_access(1'b0, BETA_ADDR, '0);
      set_gains(32'h8000_0000, 32'h7fff_ffff);
      idle_on = 1'b1;
      queue_rows(250);
      settle_block();

      // Opposite extremes, back to back, with a pause until all results are in.
      set_gains(32'h7fff_ffff, 32'h8000_0000);
      idle_on = 1'b0;
      queue_rows(120);
      queue_drain();
      queue_rows(130);
      settle_block();

      // Receiver holds off for a long stretch while the sender floods the block.
      set_gains(32'h0000_8000, 32'h0001_0000);
      long_hold_asked++;
      queue_rows(250);
      settle_block();

      set_gains($urandom, $urandom);
      idle_on = 1'b1;
      queue_rows(150);
      queue_drain();
      queue_rows(150);
      settle_block();

      set_gains(32'h0000_0000, 32'hffff_0000);
      queue_rows(100);
      settle_block();

      set_gains(32'h0001_0000, 32'h0000_0000);
      queue_rows(230);
      settle_block();

      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Hard limit on the run time.
   initial begin : watchdog
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
